### design/minimum_spanning_tree_prim_unit_defines.svh
// Assertion macros shared by the spanning tree unit.
// Expects clk and rst in scope at the point of use.
`ifndef MINIMUM_SPANNING_TREE_PRIM_UNIT_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_PRIM_UNIT_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define MST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define MST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mst_pkg.sv
// Shared types and constants for the spanning tree unit.
// No dependencies.
package mst_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam logic [5:0] VERTEX_COUNT_RST = 6'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // word index of the vertex count register
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic [4:0]  end_low;
    logic [4:0]  end_high;
    logic [14:0] edge_weight;
    logic        last_edge;
    logic        disconnected;
  } mst_result_t;

endpackage

### design/mst_wmem.sv
// Weight table: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module mst_wmem #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]    waddr,
  input  logic [WEIGHT_BITS-1:0]                          wdata,
  input  logic                                            re,
  input  logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]    raddr,
  output logic [WEIGHT_BITS-1:0]                          rdata
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/mst_ctrl.sv
// Prim sequencer: scans crossing edges through the weight table read port,
// keeps the lightest one per round and hands each tree edge out.
// Depends on mst_pkg and the assertion macro header.
`include "minimum_spanning_tree_prim_unit_defines.svh"

module mst_ctrl #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]            n_active,
  input  logic                                         res_room,
  output logic                                         rd_en,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0] rd_addr,
  input  logic [WEIGHT_BITS-1:0]                       rd_data,
  output logic                                         busy,
  output logic                                         res_push,
  output mst_pkg::mst_result_t                         res
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES+1);
  localparam int AW = $clog2(MAX_VERTICES*MAX_VERTICES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]              state;
  logic [VW-1:0]           t;
  logic [VW-1:0]           j;
  logic [VW-1:0]           round;
  logic [MAX_VERTICES-1:0] in_tree;
  logic                    found;
  logic [WEIGHT_BITS-1:0]  best_w;
  logic [VW-1:0]           best_lo;
  logic [VW-1:0]           best_hi;
  logic                    p_valid;
  logic [VW-1:0]           p_lo;
  logic [VW-1:0]           p_hi;

  logic [NW-1:0] nm1;
  logic          j_lt_t;
  logic          j_eq_t;
  logic [NW:0]   diff;
  logic [VW-1:0] other;
  logic [VW-1:0] lo;
  logic [VW-1:0] hi;
  logic          cand_v;
  logic          t_done;
  logic          scan_last;
  logic          better;
  logic          round_last;
  logic [31:0]   w32;

  assign nm1    = n_active - NW'(1);
  assign j_lt_t = j < t;
  assign j_eq_t = j == t;
  // higher others are visited from the top down: j = t+1 maps to n-1
  assign diff   = (NW+1)'(n_active) + (NW+1)'(t) - (NW+1)'(j);
  assign other  = j_lt_t ? j : VW'(diff);
  assign lo     = j_lt_t ? j : t;
  assign hi     = j_lt_t ? t : other;
  assign cand_v = !j_eq_t && in_tree[t] && !in_tree[other];

  // a vertex outside the tree has nothing to scan
  assign t_done    = !in_tree[t] || (NW'(j) == nm1);
  assign scan_last = t_done && (NW'(t) == nm1);

  assign rd_en   = state == S_SCAN;
  assign rd_addr = AW'(hi) * AW'(MAX_VERTICES) + AW'(lo);

  assign better = p_valid && !rd_data[WEIGHT_BITS-1] && (!found || rd_data < best_w);

  assign round_last = NW'(round) == (n_active - NW'(2));
  assign w32        = 32'(best_w);

  assign busy     = state != S_IDLE;
  assign res_push = (state == S_EMIT) && res_room;

  always_comb begin
    res.end_low      = found ? 5'(best_lo) : 5'd0;
    res.end_high     = found ? 5'(best_hi) : 5'd0;
    res.edge_weight  = found ? w32[14:0] : 15'd0;
    res.last_edge    = !found || round_last;
    res.disconnected = !found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_tree <= '0;
      found   <= 1'b0;
      round   <= '0;
      p_valid <= 1'b0;
      t       <= '0;
      j       <= '0;
    end else begin
      p_valid <= (state == S_SCAN) && cand_v;
      // compare the entry read in the previous cycle
      if (better) begin
        found   <= 1'b1;
        best_w  <= rd_data;
        best_lo <= p_lo;
        best_hi <= p_hi;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            in_tree <= MAX_VERTICES'(1);
            found   <= 1'b0;
            round   <= '0;
            t       <= '0;
            j       <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          p_lo    <= lo;
          p_hi    <= hi;
          if (t_done) begin
            j <= '0;
            t <= t + VW'(1);
            if (scan_last) begin
              state <= S_DRAIN;
            end
          end else begin
            j <= j + VW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_room) begin
            if (!found || round_last) begin
              state <= S_IDLE;
            end else begin
              in_tree[best_lo] <= 1'b1;
              in_tree[best_hi] <= 1'b1;
              round            <= round + VW'(1);
              found            <= 1'b0;
              t                <= '0;
              j                <= '0;
              state            <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MST_ASSERT_NOW(a_root_in_tree, state != S_IDLE, in_tree[0], "root vertex left the tree")
  `MST_ASSERT_NEXT(a_start_tree, start && !busy, in_tree == MAX_VERTICES'(1), "bad tree seed")
  `MST_ASSERT_NOW(a_edge_order, res_push && !res.disconnected, res.end_low < res.end_high, "ends swapped")
  `MST_ASSERT_NEXT(a_run_end, res_push && res.last_edge, state == S_IDLE, "run outlived last beat")
  `MST_ASSERT_NOW(a_pipe_src, p_valid, $past(state) == S_SCAN, "compare stage fed outside a scan")

endmodule

### design/minimum_spanning_tree_prim_unit.sv
// Load beats write one weight entry each and are taken one per cycle.
// A run beat blocks input until its last edge is queued; each round reads
// the crossing edges one at a time through the single read port of the
// weight memory, and each chosen edge waits in the output register until taken.
// Synchronous reset: the vertex count returns to 2 and all control clears;
// the weight memory keeps its contents and is undefined until written.
module minimum_spanning_tree_prim_unit #(
  parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [4:0]         row,
  input  logic [4:0]         col,
  input  logic signed [15:0] weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         end_low,
  output logic [4:0]         end_high,
  output logic [14:0]        edge_weight,
  output logic               last_edge,
  output logic               disconnected
);

  localparam int NW = $clog2(MAX_VERTICES+1);
  localparam int AW = $clog2(MAX_VERTICES*MAX_VERTICES);
  localparam logic [31:0] WMAX = 32'((64'd1 << (WEIGHT_BITS-1)) - 64'd1);

  logic [5:0] vtx_count;
  logic       cfg_wr;

  logic [NW-1:0]          n_active;
  logic                   accept;
  logic                   start;
  logic                   load;
  logic [AW-1:0]          waddr;
  logic [WEIGHT_BITS-1:0] wdata;
  logic [31:0]            wpos;

  logic                   busy;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic                   res_room;
  logic                   res_push;
  mst_pkg::mst_result_t   res;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == mst_pkg::REG_VERTEX_COUNT);
  assign prdata = (paddr[2] == mst_pkg::REG_VERTEX_COUNT) ? 32'(vtx_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_count <= mst_pkg::VERTEX_COUNT_RST;
    end else if (cfg_wr) begin
      vtx_count <= pwdata[5:0];
    end
  end

  always_comb begin
    if (vtx_count < 6'd2) begin
      n_active = NW'(2);
    end else if (32'(vtx_count) > 32'(MAX_VERTICES)) begin
      n_active = NW'(MAX_VERTICES);
    end else begin
      n_active = NW'(vtx_count);
    end
  end

  // input side
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (cmd == mst_pkg::CMD_RUN);
  assign load     = accept && (cmd == mst_pkg::CMD_LOAD) &&
                    (32'(row) < 32'(MAX_VERTICES)) && (32'(col) < 32'(MAX_VERTICES));
  assign waddr    = AW'(row) * AW'(MAX_VERTICES) + AW'(col);

  // clamp: any negative weight becomes -1, large ones saturate
  assign wpos = 32'(weight[14:0]);
  always_comb begin
    if (weight[15]) begin
      wdata = '1;
    end else if (wpos > WMAX) begin
      wdata = WMAX[WEIGHT_BITS-1:0];
    end else begin
      wdata = wpos[WEIGHT_BITS-1:0];
    end
  end

  mst_wmem #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_wmem (
    .clk   (clk),
    .we    (load),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mst_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .n_active (n_active),
    .res_room (res_room),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (busy),
    .res_push (res_push),
    .res      (res)
  );

  // output register: hold a beat until taken
  assign res_room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      end_low      <= res.end_low;
      end_high     <= res.end_high;
      edge_weight  <= res.edge_weight;
      last_edge    <= res.last_edge;
      disconnected <= res.disconnected;
    end
  end

endmodule

### test/minimum_spanning_tree_prim_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for minimum_spanning_tree_prim_unit: weight loads and tree runs
// are driven through the beat channel and every emitted edge is checked in order.
// Depends on mst_pkg for the command codes, register index and result layout.
module minimum_spanning_tree_prim_unit_tb;

  localparam int          NV           = mst_pkg::MAX_VERTICES_DEF;
  localparam int          LIMIT        = 2_000_000;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          SETTLE_CYCLES = 64;
  localparam logic [2:0]  VC_ADDR      = {mst_pkg::REG_VERTEX_COUNT, 2'b00};

  localparam mst_pkg::mst_result_t NO_EDGE  = '0;
  localparam mst_pkg::mst_result_t DISC_END = '{5'd0, 5'd0, 15'd0, 1'b1, 1'b1};

  typedef enum logic [1:0] {STEP_LOAD, STEP_RUN, STEP_CFG} step_kind_t;

  // arg is the row of a load or the register value of a configuration step
  typedef struct packed {
    step_kind_t           kind;
    logic [5:0]           arg;
    logic [4:0]           col_v;
    logic signed [15:0]   wt;
    logic                 typed;
    mst_pkg::mst_result_t fixed;
  } step_t;

  typedef struct {
    logic                 cmd;
    logic [4:0]           row_v;
    logic [4:0]           col_v;
    logic signed [15:0]   wt;
    bit                   typed;
    mst_pkg::mst_result_t fixed;
  } beat_t;

  localparam int DIRECTED_LEN = 24;
  localparam step_t DIRECTED [DIRECTED_LEN] = '{
    '{STEP_LOAD, 6'd1,  5'd0,  16'sd32767, 1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b1, '{5'd0, 5'd1, 15'd32767, 1'b1, 1'b0}},
    '{STEP_LOAD, 6'd1,  5'd0,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b1, '{5'd0, 5'd1, 15'd0, 1'b1, 1'b0}},
    '{STEP_LOAD, 6'd1,  5'd0,  -16'sd1,    1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b1, DISC_END},
    '{STEP_LOAD, 6'd1,  5'd0,  16'sh8000,  1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b1, DISC_END},
    '{STEP_LOAD, 6'd1,  5'd0,  16'sd7,     1'b0, NO_EDGE},
    '{STEP_CFG,  6'd3,  5'd0,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_LOAD, 6'd2,  5'd0,  16'sd7,     1'b0, NO_EDGE},
    '{STEP_LOAD, 6'd2,  5'd1,  16'sd7,     1'b0, NO_EDGE},
    // diagonal and upper triangle are never consulted
    '{STEP_LOAD, 6'd1,  5'd1,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_LOAD, 6'd0,  5'd2,  16'sd1,     1'b0, NO_EDGE},
    '{STEP_LOAD, 6'd31, 5'd31, -16'sd1,    1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_CFG,  6'd0,  5'd0,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b1, '{5'd0, 5'd1, 15'd7, 1'b1, 1'b0}},
    '{STEP_CFG,  6'd3,  5'd0,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_LOAD, 6'd2,  5'd0,  -16'sd1,    1'b0, NO_EDGE},
    '{STEP_LOAD, 6'd2,  5'd1,  -16'sd1,    1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_CFG,  6'd1,  5'd0,  16'sd0,     1'b0, NO_EDGE},
    '{STEP_RUN,  6'd0,  5'd0,  16'sd0,     1'b1, '{5'd0, 5'd1, 15'd7, 1'b1, 1'b0}}
  };

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic [4:0]         row;
  logic [4:0]         col;
  logic signed [15:0] weight;
  logic               out_valid;
  logic               out_stall;
  logic [4:0]         end_low;
  logic [4:0]         end_high;
  logic [14:0]        edge_weight;
  logic               last_edge;
  logic               disconnected;

  minimum_spanning_tree_prim_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .row(row), .col(col), .weight(weight),
    .out_valid(out_valid), .out_stall(out_stall),
    .end_low(end_low), .end_high(end_high), .edge_weight(edge_weight),
    .last_edge(last_edge), .disconnected(disconnected)
  );

  // predictor state
  int                   weight_table [NV][NV];
  logic [5:0]           vc_raw;
  mst_pkg::mst_result_t tree_edges [$];
  mst_pkg::mst_result_t edges_due [$];

  // stimulus bookkeeping
  beat_t                beats_to_send [$];
  beat_t                drive_beat;
  bit                   loaded [NV][NV];
  int                   total_beats;
  int                   runs_seen;
  bit                   hold_armed;
  bit                   hold_done;
  int                   err_count;
  int                   cycles;
  mst_pkg::mst_result_t got;
  mst_pkg::mst_result_t want;

  function automatic void log_miss(string msg);
    if (err_count < 10) $display("MISMATCH: %s", msg);
    err_count++;
  endfunction

  function automatic int live_vertices();
    if (vc_raw < 6'd2) return 2;
    if (vc_raw > 6'(NV)) return NV;
    return int'(vc_raw);
  endfunction

  // Grow the tree from vertex 0; the first strictly lighter crossing edge wins.
  function automatic void grow_tree();
    int                   n;
    logic [31:0]          member;
    bit                   found;
    int                   best_w;
    int                   best_lo;
    int                   best_hi;
    int                   other;
    int                   w;
    mst_pkg::mst_result_t res;
    n = live_vertices();
    tree_edges.delete();
    member = 32'd1;
    for (int rnd = 0; rnd + 1 < n; rnd++) begin
      found = 1'b0;
      best_w = 0;
      best_lo = 0;
      best_hi = 0;
      for (int t = 0; t < n; t++) begin
        if (!member[t]) continue;
        for (int a = 0; a < n; a++) begin
          for (int b = n - 1; b > a; b--) begin
            if (a == t) other = b;
            else if (b == t) other = a;
            else continue;
            if (member[other]) continue;
            w = weight_table[b][a];
            if (w < 0) continue;
            if (!found || w < best_w) begin
              found = 1'b1;
              best_w = w;
              best_lo = a;
              best_hi = b;
            end
          end
        end
      end
      if (!found) begin
        tree_edges = {tree_edges, DISC_END};
        return;
      end
      member[best_lo] = 1'b1;
      member[best_hi] = 1'b1;
      res.end_low      = 5'(best_lo);
      res.end_high     = 5'(best_hi);
      res.edge_weight  = 15'(best_w);
      res.last_edge    = (rnd + 2 == n);
      res.disconnected = 1'b0;
      tree_edges = {tree_edges, res};
    end
  endfunction

  function automatic logic signed [15:0] rand_weight();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 16'($urandom_range(0, 7));
    if (pick < 52) return -16'sd1;
    if (pick < 58) return 16'h8000 | 16'($urandom_range(0, 32767));
    if (pick < 95) return 16'($urandom_range(0, 32767));
    return 16'sd32767;
  endfunction

  task automatic queue_load(input int r, input int c, input logic signed [15:0] w);
    beat_t bt;
    bt.cmd   = mst_pkg::CMD_LOAD;
    bt.row_v = 5'(r);
    bt.col_v = 5'(c);
    bt.wt    = w;
    bt.typed = 1'b0;
    bt.fixed = NO_EDGE;
    beats_to_send = {beats_to_send, bt};
    loaded[r][c] = 1'b1;
    total_beats++;
  endtask

  task automatic queue_run(input bit typed, input mst_pkg::mst_result_t fixed);
    beat_t bt;
    bt.cmd   = mst_pkg::CMD_RUN;
    bt.row_v = 5'($urandom_range(0, 31));
    bt.col_v = 5'($urandom_range(0, 31));
    bt.wt    = 16'($urandom);
    bt.typed = typed;
    bt.fixed = fixed;
    beats_to_send = {beats_to_send, bt};
    total_beats++;
  endtask

  // Wait until every queued beat is taken and every edge has come back.
  task automatic settle();
    while (beats_to_send.size() != 0 || in_valid || edges_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [5:0] value);
    logic [31:0] data;
    data = ($urandom & 32'hFFFF_FFC0) | 32'(value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = VC_ADDR;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    vc_raw = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'd0, value})
      log_miss($sformatf("vertex count read %0h, want %0h", prdata, value));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sender: bursts of back-to-back beats separated by random gaps.
  initial begin : beat_sender
    int burst_left;
    int gap_left;
    burst_left = 0;
    gap_left = 0;
    in_valid = 1'b0;
    cmd = mst_pkg::CMD_LOAD;
    row = '0;
    col = '0;
    weight = '0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (gap_left > 0 || beats_to_send.size() == 0) begin
        in_valid = 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        drive_beat = beats_to_send.pop_front();
        cmd = drive_beat.cmd;
        row = drive_beat.row_v;
        col = drive_beat.col_v;
        weight = drive_beat.wt;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 7))
            0, 1, 2, 3: gap_left = 0;
            7:          gap_left = $urandom_range(10, 40);
            default:    gap_left = $urandom_range(1, 5);
          endcase
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off during a run.
  initial begin : edge_receiver
    int seg;
    int mode;
    out_stall = 1'b0;
    forever begin
      seg = $urandom_range(5, 60);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(negedge clk);
        if (hold_armed && !hold_done) begin
          out_stall = 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_done = 1'b1;
        end else begin
          case (mode)
            0:       out_stall = 1'b0;
            1:       out_stall = ($urandom_range(0, 3) == 0);
            2:       out_stall = ($urandom_range(0, 1) == 0);
            default: out_stall = ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // Check each edge beat, then fold each accepted input beat into the predictor.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{end_low, end_high, edge_weight, last_edge, disconnected};
        if (edges_due.size() == 0) begin
          log_miss($sformatf("edge %0d-%0d w%0d last %b disc %b with none expected",
                             got.end_low, got.end_high, got.edge_weight,
                             got.last_edge, got.disconnected));
        end else begin
          want = edges_due.pop_front();
          if (got.end_low !== want.end_low || got.end_high !== want.end_high ||
              got.edge_weight !== want.edge_weight ||
              got.last_edge !== want.last_edge ||
              got.disconnected !== want.disconnected)
            log_miss($sformatf("edge got %0d-%0d w%0d l%b d%b, want %0d-%0d w%0d l%b d%b",
                               got.end_low, got.end_high, got.edge_weight,
                               got.last_edge, got.disconnected,
                               want.end_low, want.end_high, want.edge_weight,
                               want.last_edge, want.disconnected));
        end
      end
      if (in_valid && !in_stall) begin
        if (drive_beat.cmd == mst_pkg::CMD_LOAD) begin
          weight_table[drive_beat.row_v][drive_beat.col_v] =
            (drive_beat.wt < 0) ? -1 : int'(drive_beat.wt);
        end else begin
          runs_seen++;
          if (drive_beat.typed) begin
            edges_due = {edges_due, drive_beat.fixed};
          end else begin
            grow_tree();
            edges_due = {edges_due, tree_edges};
          end
          if (runs_seen >= 8 && !hold_armed && beats_to_send.size() > 4 &&
              live_vertices() >= 3)
            hold_armed = 1'b1;
        end
      end
    end
  end

  initial begin : main_flow
    int          phase;
    int          n;
    bit          big;
    logic [5:0]  raw;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    vc_raw = mst_pkg::VERTEX_COUNT_RST;
    total_beats = 0;
    runs_seen = 0;
    hold_armed = 1'b0;
    hold_done = 1'b0;
    err_count = 0;
    cycles = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      case (DIRECTED[i].kind)
        STEP_CFG: begin
          settle();
          set_vertex_count(DIRECTED[i].arg);
        end
        STEP_LOAD: queue_load(int'(DIRECTED[i].arg), int'(DIRECTED[i].col_v),
                              DIRECTED[i].wt);
        default:   queue_run(DIRECTED[i].typed, DIRECTED[i].fixed);
      endcase
    end

    phase = 0;
    while (phase < 6 || total_beats < 330) begin
      if (phase == 1) raw = 6'd63;
      else if (phase == 4) raw = 6'd32;
      else begin
        case ($urandom_range(0, 7))
          0:       raw = 6'($urandom_range(0, 1));
          1:       raw = 6'($urandom_range(10, 16));
          default: raw = 6'($urandom_range(2, 9));
        endcase
      end
      settle();
      set_vertex_count(raw);
      n = live_vertices();
      big = (n == NV);
      repeat ($urandom_range(0, 4))
        queue_load(int'($urandom_range(0, 31)), int'($urandom_range(0, 31)),
                   rand_weight());
      if (big) begin
        // star from vertex 0: only the top vertex can join, then the run cuts off,
        // so every entry the run reads is written without loading the full table
        for (int b = 1; b < n; b++)
          queue_load(b, 0, (b == n - 1) ? 16'($urandom_range(0, 32767)) : -16'sd1);
        for (int a = 1; a < n - 1; a++)
          queue_load(n - 1, a, -16'sd1);
        queue_run(1'b0, NO_EDGE);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          // every pair the run reads must hold a written weight
          for (int b = 1; b < n; b++)
            for (int a = 0; a < b; a++)
              if (!loaded[b][a] || $urandom_range(0, 2) == 0)
                queue_load(b, a, rand_weight());
          repeat ($urandom_range(0, 2))
            queue_load(int'($urandom_range(0, 31)), int'($urandom_range(0, 31)),
                       rand_weight());
          queue_run(1'b0, NO_EDGE);
        end
      end
      phase++;
    end

    settle();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
